### hdl/mlspi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlspi_pkg;

  // MISO lanes wired to the block
  localparam int LANES   = 17;
  localparam int LANE_IW = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int CNT_W   = 5;   // sensor count, lane index
  localparam int VALUE_W = 16;  // captured word

  // Strobes from the sequencer to the lane capture bank
  typedef struct packed {
    logic             clear;  // zero enabled lanes before a new word
    logic             shift;  // shift one MISO bit into enabled lanes
    logic [CNT_W-1:0] lanes;  // number of enabled lanes
  } mlspi_bank_ctl_t;

endpackage

`default_nettype wire

### hdl/multi_lane_spi_command_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// in_       in_valid / in_stall   opcode, miso_lanes, four command bytes, counts
// out_      out_valid / out_stall pin levels, busy, lane result, last
// cfg_      cfg_write_en          cfg_write_data = sensor_count
//
// Each input transaction advances the SPI waveform by one phase at the edge
// that accepts it and yields 1 result, or 1 + lane count when a status byte or
// data word completes, presented from the next cycle, one per cycle while
// out_stall is low. in_stall stays high until the last result leaves, so a new
// item is accepted only after every result of the previous one is taken.
// Reset puts CS, SCLK and MOSI high, the sequencer idle and sensor_count at 1.

module multi_lane_spi_command_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          cfg_write_en,
  input  wire logic [mlspi_pkg::CNT_W-1:0]   cfg_write_data,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [mlspi_pkg::LANES-1:0]   in_miso_lanes,
  input  wire logic [7:0]                    in_command_byte,
  input  wire logic [7:0]                    in_second_byte,
  input  wire logic [7:0]                    in_third_byte,
  input  wire logic [7:0]                    in_fourth_byte,
  input  wire logic [2:0]                    in_write_count,
  input  wire logic [2:0]                    in_read_words,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_chip_select_n,
  output logic                               out_serial_clock,
  output logic                               out_serial_out,
  output logic                               out_busy_res,
  output logic                               out_lane_result_valid,
  output logic [mlspi_pkg::CNT_W-1:0]        out_lane_index,
  output logic [2:0]                         out_word_kind,
  output logic [mlspi_pkg::VALUE_W-1:0]      out_captured_value,
  output logic                               out_last
);
  import mlspi_pkg::*;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_LEAD   = 4'd1;
  localparam logic [3:0] PH_WLOW   = 4'd2;
  localparam logic [3:0] PH_WHIGH  = 4'd3;
  localparam logic [3:0] PH_WGAP   = 4'd4;
  localparam logic [3:0] PH_RLOW   = 4'd5;
  localparam logic [3:0] PH_RHIGH  = 4'd6;
  localparam logic [3:0] PH_RGAP   = 4'd7;
  localparam logic [3:0] PH_FINISH = 4'd8;

  localparam logic OP_START = 1'b1;

  localparam logic [2:0] LEAD_LAST = 3'd4;  // gap after CS falls
  localparam logic [2:0] GAP_LAST  = 3'd3;  // gap after each command byte

  // Waveform state
  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  tick_r, tick_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [2:0]  word_r, word_nxt;
  logic [31:0] cmd_r, cmd_nxt;
  logic [2:0]  write_total_r, write_total_nxt;
  logic [2:0]  read_total_r, read_total_nxt;
  logic        cs_r, cs_nxt;
  logic        sclk_r, sclk_nxt;
  logic        mosi_r, mosi_nxt;
  logic [CNT_W-1:0] sensor_count_r;

  // Result emission
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;        // 0 = pin result, k = lane k-1
  logic [CNT_W-1:0] burst_n_r, burst_n_nxt;
  logic [2:0]       kind_r, kind_nxt;

  logic             in_acc;
  logic [CNT_W-1:0] lanes_eff;
  logic [4:0]       bit_inc;
  logic [4:0]       read_len;
  logic [2:0]       word_inc;
  mlspi_bank_ctl_t  bank_ctl;
  logic [VALUE_W-1:0] lane_value;

  assign in_stall = out_valid_r;
  assign in_acc   = in_valid && !out_valid_r;

  // Clamp the lane count to the wired lanes.
  assign lanes_eff = (32'(sensor_count_r) > LANES) ? CNT_W'(LANES) : sensor_count_r;
  assign bit_inc   = bit_r + 5'd1;
  assign word_inc  = word_r + 3'd1;
  assign read_len  = (word_r == 3'd0) ? 5'd8 : 5'd16;

  always_comb begin
    phase_nxt       = phase_r;
    tick_nxt        = tick_r;
    bit_nxt         = bit_r;
    byte_nxt        = byte_r;
    word_nxt        = word_r;
    cmd_nxt         = cmd_r;
    write_total_nxt = write_total_r;
    read_total_nxt  = read_total_r;
    cs_nxt          = cs_r;
    sclk_nxt        = sclk_r;
    mosi_nxt        = mosi_r;
    out_valid_nxt   = out_valid_r;
    pos_nxt         = pos_r;
    burst_n_nxt     = burst_n_r;
    kind_nxt        = kind_r;
    bank_ctl.clear  = 1'b0;
    bank_ctl.shift  = 1'b0;
    bank_ctl.lanes  = lanes_eff;

    if (in_acc) begin
      // Every transaction returns at least the pin result.
      out_valid_nxt = 1'b1;
      pos_nxt       = '0;
      burst_n_nxt   = '0;
      kind_nxt      = 3'd0;

      if (in_opcode == OP_START) begin
        // Start while busy is dropped.
        if (phase_r == PH_IDLE) begin
          cmd_nxt = {in_command_byte, in_second_byte, in_third_byte, in_fourth_byte};
          if (in_write_count == 3'd0) begin
            write_total_nxt = 3'd1;
          end else if (in_write_count > 3'd4) begin
            write_total_nxt = 3'd4;
          end else begin
            write_total_nxt = in_write_count;
          end
          read_total_nxt = (in_read_words > 3'd4) ? 3'd4 : in_read_words;
          tick_nxt  = '0;
          bit_nxt   = '0;
          byte_nxt  = '0;
          word_nxt  = '0;
          cs_nxt    = 1'b0;
          sclk_nxt  = 1'b1;
          phase_nxt = PH_LEAD;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_LEAD: begin
            tick_nxt = tick_r + 3'd1;
            if (tick_nxt >= LEAD_LAST) begin
              tick_nxt  = '0;
              bit_nxt   = '0;
              phase_nxt = PH_WLOW;
            end
          end
          PH_WLOW: begin
            // Command bits leave MSB first, one per low phase.
            sclk_nxt  = 1'b0;
            mosi_nxt  = cmd_r[31];
            cmd_nxt   = {cmd_r[30:0], 1'b0};
            phase_nxt = PH_WHIGH;
          end
          PH_WHIGH: begin
            sclk_nxt = 1'b1;
            if (bit_inc >= 5'd8) begin
              bit_nxt   = '0;
              byte_nxt  = byte_r + 3'd1;
              tick_nxt  = '0;
              phase_nxt = PH_WGAP;
            end else begin
              bit_nxt   = bit_inc;
              phase_nxt = PH_WLOW;
            end
          end
          PH_WGAP: begin
            tick_nxt = tick_r + 3'd1;
            if (tick_nxt >= GAP_LAST) begin
              tick_nxt = '0;
              bit_nxt  = '0;
              if (byte_r >= write_total_r) begin
                word_nxt  = '0;
                phase_nxt = PH_RLOW;
              end else begin
                phase_nxt = PH_WLOW;
              end
            end
          end
          PH_RLOW: begin
            bank_ctl.clear = (bit_r == 5'd0);
            sclk_nxt       = 1'b0;
            phase_nxt      = PH_RHIGH;
          end
          PH_RHIGH: begin
            sclk_nxt       = 1'b1;
            bank_ctl.shift = 1'b1;
            if (bit_inc >= read_len) begin
              // Word complete: report every enabled lane.
              burst_n_nxt = lanes_eff;
              kind_nxt    = word_r;
              bit_nxt     = '0;
              word_nxt    = word_inc;
              if (word_inc > read_total_r) begin
                phase_nxt = PH_FINISH;
              end else if (word_r == 3'd0) begin
                phase_nxt = PH_RLOW;
              end else begin
                phase_nxt = PH_RGAP;
              end
            end else begin
              bit_nxt   = bit_inc;
              phase_nxt = PH_RLOW;
            end
          end
          PH_RGAP: begin
            phase_nxt = PH_RLOW;
          end
          PH_FINISH: begin
            cs_nxt    = 1'b1;
            sclk_nxt  = 1'b1;
            mosi_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end else if (out_valid_r && !out_stall) begin
      // Advance through the lane results, then release the input side.
      if (pos_r == burst_n_r) begin
        out_valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      tick_r         <= '0;
      bit_r          <= '0;
      byte_r         <= '0;
      word_r         <= '0;
      write_total_r  <= 3'd1;
      read_total_r   <= '0;
      cs_r           <= 1'b1;
      sclk_r         <= 1'b1;
      mosi_r         <= 1'b1;
      sensor_count_r <= CNT_W'(1);
      out_valid_r    <= 1'b0;
      pos_r          <= '0;
      burst_n_r      <= '0;
      kind_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      tick_r        <= tick_nxt;
      bit_r         <= bit_nxt;
      byte_r        <= byte_nxt;
      word_r        <= word_nxt;
      write_total_r <= write_total_nxt;
      read_total_r  <= read_total_nxt;
      cs_r          <= cs_nxt;
      sclk_r        <= sclk_nxt;
      mosi_r        <= mosi_nxt;
      out_valid_r   <= out_valid_nxt;
      pos_r         <= pos_nxt;
      burst_n_r     <= burst_n_nxt;
      kind_r        <= kind_nxt;
      if (cfg_write_en) begin
        sensor_count_r <= cfg_write_data;
      end
    end
  end

  // Command shifter carries no control meaning; no reset.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  mlspi_lane_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bank_ctl),
    .miso    (in_miso_lanes),
    .rd_idx  (LANE_IW'(pos_r - CNT_W'(1))),
    .rd_data (lane_value)
  );

  // All result fields come from registers held until the result is taken.
  assign out_valid             = out_valid_r;
  assign out_chip_select_n     = cs_r;
  assign out_serial_clock      = sclk_r;
  assign out_serial_out        = mosi_r;
  assign out_busy_res          = (phase_r != PH_IDLE);
  assign out_lane_result_valid = (pos_r != '0);
  assign out_lane_index        = (pos_r != '0) ? (pos_r - CNT_W'(1)) : '0;
  assign out_word_kind         = (pos_r != '0) ? kind_r : 3'd0;
  assign out_captured_value    = (pos_r != '0) ? lane_value : '0;
  assign out_last              = (pos_r == burst_n_r);

endmodule

`default_nettype wire

### hdl/mlspi_lane_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module mlspi_lane_bank (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mlspi_pkg::mlspi_bank_ctl_t    ctl,
  input  wire logic [mlspi_pkg::LANES-1:0]   miso,
  input  wire logic [mlspi_pkg::LANE_IW-1:0] rd_idx,
  output logic [mlspi_pkg::VALUE_W-1:0]      rd_data
);
  import mlspi_pkg::*;

  logic [VALUE_W-1:0] shift_r [LANES];

  // One bit per lane per SCLK rising phase; lanes beyond the count hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        shift_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        if (CNT_W'(i) < ctl.lanes) begin
          if (ctl.clear) begin
            shift_r[i] <= '0;
          end else if (ctl.shift) begin
            shift_r[i] <= {shift_r[i][VALUE_W-2:0], miso[i]};
          end
        end
      end
    end
  end

  assign rd_data = shift_r[rd_idx];

endmodule

`default_nettype wire

### test/mlspi_result_checker.sv
`timescale 1ns / 1ps

package mlspi_tb_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } spi_op_t;

endpackage

module mlspi_result_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_en,
  input  wire logic [mlspi_pkg::CNT_W-1:0]   cfg_write_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [mlspi_pkg::LANES-1:0]   in_miso_lanes,
  input  wire logic [7:0]                    in_command_byte,
  input  wire logic [7:0]                    in_second_byte,
  input  wire logic [7:0]                    in_third_byte,
  input  wire logic [7:0]                    in_fourth_byte,
  input  wire logic [2:0]                    in_write_count,
  input  wire logic [2:0]                    in_read_words,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_chip_select_n,
  input  wire logic                          out_serial_clock,
  input  wire logic                          out_serial_out,
  input  wire logic                          out_busy_res,
  input  wire logic                          out_lane_result_valid,
  input  wire logic [mlspi_pkg::CNT_W-1:0]   out_lane_index,
  input  wire logic [2:0]                    out_word_kind,
  input  wire logic [mlspi_pkg::VALUE_W-1:0] out_captured_value,
  input  wire logic                          out_last,
  output logic [31:0]                        error_total,
  output logic [31:0]                        results_owed,
  output logic [31:0]                        lane_captures
);
  import mlspi_pkg::*;
  import mlspi_tb_pkg::*;

  localparam int LEAD_TICKS     = 4;
  localparam int BYTE_GAP_TICKS = 3;
  localparam int STATUS_BITS    = 8;
  localparam int WORD_BITS      = 16;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_LEAD,
    SEQ_WLOW,
    SEQ_WHIGH,
    SEQ_WGAP,
    SEQ_RLOW,
    SEQ_RHIGH,
    SEQ_RGAP,
    SEQ_FINISH
  } seq_phase_t;

  typedef struct packed {
    logic               cs_n;
    logic               sclk;
    logic               mosi;
    logic               busy;
    logic               lane_valid;
    logic [CNT_W-1:0]   lane;
    logic [2:0]         kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } spi_result_t;

  spi_result_t owed_q[$];

  logic [CNT_W-1:0]   sensor_cnt;
  seq_phase_t         phase;
  logic [2:0]         tick_cnt;
  logic [4:0]         bit_cnt;
  logic [2:0]         byte_cnt;
  logic [2:0]         word_cnt;
  logic [31:0]        cmd_word;
  logic [2:0]         write_total;
  logic [2:0]         read_total;
  logic [VALUE_W-1:0] lane_word [LANES];
  logic               cs_n;
  logic               sclk;
  logic               mosi;

  task automatic reset_model();
    sensor_cnt  = 5'd1;
    phase       = SEQ_IDLE;
    tick_cnt    = '0;
    bit_cnt     = '0;
    byte_cnt    = '0;
    word_cnt    = '0;
    cmd_word    = '0;
    write_total = 3'd1;
    read_total  = '0;
    for (int i = 0; i < LANES; i++) lane_word[i] = '0;
    cs_n = 1'b1;
    sclk = 1'b1;
    mosi = 1'b1;
    owed_q.delete();
    error_total   = '0;
    lane_captures = '0;
  endtask

  // Advance the waveform by one phase and queue the pin result plus any lane burst.
  task automatic advance_waveform(input logic op, input logic [LANES-1:0] miso,
                                  input logic [31:0] cmd, input logic [2:0] wc,
                                  input logic [2:0] rw);
    int          lanes;
    int          len;
    logic        burst;
    logic [2:0]  kind;
    logic [7:0]  cur;
    spi_result_t r;
    lanes = (sensor_cnt > LANES) ? LANES : int'(sensor_cnt);
    burst = 1'b0;
    kind  = '0;
    if (op == OP_START) begin
      if (phase == SEQ_IDLE) begin
        cmd_word    = cmd;
        write_total = (wc == 3'd0) ? 3'd1 : ((wc > 3'd4) ? 3'd4 : wc);
        read_total  = (rw > 3'd4) ? 3'd4 : rw;
        tick_cnt    = '0;
        bit_cnt     = '0;
        byte_cnt    = '0;
        word_cnt    = '0;
        cs_n        = 1'b0;
        sclk        = 1'b1;
        phase       = SEQ_LEAD;
      end
    end else begin
      case (phase)
        SEQ_LEAD: begin
          tick_cnt = tick_cnt + 3'd1;
          if (tick_cnt >= LEAD_TICKS) begin
            tick_cnt = '0;
            bit_cnt  = '0;
            phase    = SEQ_WLOW;
          end
        end
        SEQ_WLOW: begin
          cur   = cmd_word[8 * (3 - int'(byte_cnt[1:0])) +: 8];
          sclk  = 1'b0;
          mosi  = cur[7 - int'(bit_cnt[2:0])];
          phase = SEQ_WHIGH;
        end
        SEQ_WHIGH: begin
          sclk    = 1'b1;
          bit_cnt = bit_cnt + 5'd1;
          if (bit_cnt >= 8) begin
            bit_cnt  = '0;
            byte_cnt = byte_cnt + 3'd1;
            tick_cnt = '0;
            phase    = SEQ_WGAP;
          end else begin
            phase = SEQ_WLOW;
          end
        end
        SEQ_WGAP: begin
          tick_cnt = tick_cnt + 3'd1;
          if (tick_cnt >= BYTE_GAP_TICKS) begin
            tick_cnt = '0;
            bit_cnt  = '0;
            if (byte_cnt >= write_total) begin
              word_cnt = '0;
              phase    = SEQ_RLOW;
            end else begin
              phase = SEQ_WLOW;
            end
          end
        end
        SEQ_RLOW: begin
          if (bit_cnt == 5'd0)
            for (int i = 0; i < lanes; i++) lane_word[i] = '0;
          sclk  = 1'b0;
          phase = SEQ_RHIGH;
        end
        SEQ_RHIGH: begin
          len  = (word_cnt == 3'd0) ? STATUS_BITS : WORD_BITS;
          sclk = 1'b1;
          for (int i = 0; i < lanes; i++) lane_word[i] = {lane_word[i][VALUE_W-2:0], miso[i]};
          bit_cnt = bit_cnt + 5'd1;
          if (bit_cnt >= len) begin
            burst    = 1'b1;
            kind     = word_cnt;
            bit_cnt  = '0;
            word_cnt = word_cnt + 3'd1;
            if (word_cnt > read_total) phase = SEQ_FINISH;
            else if (kind == 3'd0)     phase = SEQ_RLOW;
            else                       phase = SEQ_RGAP;
          end else begin
            phase = SEQ_RLOW;
          end
        end
        SEQ_RGAP: phase = SEQ_RLOW;
        SEQ_FINISH: begin
          cs_n  = 1'b1;
          sclk  = 1'b1;
          mosi  = 1'b1;
          phase = SEQ_IDLE;
        end
        default: ;
      endcase
    end

    if (!burst) lanes = 0;
    r      = '0;
    r.cs_n = cs_n;
    r.sclk = sclk;
    r.mosi = mosi;
    r.busy = (phase != SEQ_IDLE);
    r.last = (lanes == 0);
    owed_q.push_back(r);
    for (int i = 0; i < lanes; i++) begin
      r.lane_valid = 1'b1;
      r.lane       = CNT_W'(i);
      r.kind       = kind;
      r.value      = lane_word[i];
      r.last       = (i == lanes - 1);
      owed_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_total = error_total + 1;
    end
  endtask

  always @(posedge clk) begin
    spi_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_write_en) sensor_cnt = cfg_write_data;
      if (in_valid && !in_stall)
        advance_waveform(in_opcode, in_miso_lanes,
                         {in_command_byte, in_second_byte, in_third_byte, in_fourth_byte},
                         in_write_count, in_read_words);
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result transaction with no expected result outstanding");
          error_total = error_total + 1;
        end else begin
          want = owed_q.pop_front();
          check_field("chip_select_n", want.cs_n, out_chip_select_n);
          check_field("serial_clock", want.sclk, out_serial_clock);
          check_field("serial_out", want.mosi, out_serial_out);
          check_field("busy_res", want.busy, out_busy_res);
          check_field("lane_result_valid", want.lane_valid, out_lane_result_valid);
          check_field("lane_index", want.lane, out_lane_index);
          check_field("word_kind", want.kind, out_word_kind);
          check_field("captured_value", want.value, out_captured_value);
          check_field("last", want.last, out_last);
          if (want.lane_valid) lane_captures = lane_captures + 1;
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

### test/multi_lane_spi_command_engine_tb.sv
`timescale 1ns / 1ps

module multi_lane_spi_command_engine_tb;
  import mlspi_pkg::*;
  import mlspi_tb_pkg::*;

  // MISO patterns applied during the ticks of a transfer
  typedef enum int {
    MISO_RANDOM,
    MISO_HIGH,
    MISO_LOW,
    MISO_TOGGLE
  } miso_mode_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_write_en;
  logic [CNT_W-1:0]   cfg_write_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic [LANES-1:0]   in_miso_lanes;
  logic [7:0]         in_command_byte;
  logic [7:0]         in_second_byte;
  logic [7:0]         in_third_byte;
  logic [7:0]         in_fourth_byte;
  logic [2:0]         in_write_count;
  logic [2:0]         in_read_words;
  logic               out_valid;
  logic               out_stall;
  logic               out_chip_select_n;
  logic               out_serial_clock;
  logic               out_serial_out;
  logic               out_busy_res;
  logic               out_lane_result_valid;
  logic [CNT_W-1:0]   out_lane_index;
  logic [2:0]         out_word_kind;
  logic [VALUE_W-1:0] out_captured_value;
  logic               out_last;
  wire  [31:0]        error_total;
  wire  [31:0]        results_owed;
  wire  [31:0]        lane_captures;

  // Ticks still needed to bring the current transfer back to idle; zero when idle
  int ticks_left;
  int items_sent;
  int xfers_started;
  int configs_written;
  bit steady_tx;

  multi_lane_spi_command_engine u_top (.*);

  mlspi_result_checker u_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs or loses results
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Phases per transfer: lead gap, clock phases plus a gap per command
  // byte, clock phases for the status byte and for each word with a gap
  // between data words, and the tick that raises CS.
  function automatic int xfer_ticks(input logic [2:0] wc, input logic [2:0] rw);
    int wt;
    int rt;
    wt = (wc == 3'd0) ? 1 : ((wc > 3'd4) ? 4 : int'(wc));
    rt = (rw > 3'd4) ? 4 : int'(rw);
    return 4 + 19 * wt + 16 + 32 * rt + ((rt > 0) ? rt - 1 : 0) + 1;
  endfunction

  function automatic logic [LANES-1:0] pick_miso(input miso_mode_t mode);
    logic [31:0]      w;
    logic [LANES-1:0] alt;
    w   = $urandom();
    alt = LANES'({(LANES + 1) / 2 {2'b01}});
    case (mode)
      MISO_HIGH:   return '1;
      MISO_LOW:    return '0;
      MISO_TOGGLE: return items_sent[0] ? alt : ~alt;
      default:     return w[LANES-1:0];
    endcase
  endfunction

  // Mostly one or two command bytes; now and then the clamped values
  function automatic logic [2:0] pick_write_count();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) return 3'($urandom_range(1, 2));
    if (r < 85) return 3'($urandom_range(3, 4));
    v = $urandom_range(4, 7);
    return (v == 4) ? 3'd0 : 3'(v);
  endfunction

  function automatic logic [2:0] pick_read_words();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 3'($urandom_range(0, 1));
    if (r < 85) return 3'($urandom_range(2, 4));
    return 3'($urandom_range(5, 7));
  endfunction

  // Offer one input transaction and hold it until accepted. Returns at the
  // falling edge after acceptance with in_valid still high; the caller
  // either offers the next item or drops valid in that same step.
  task automatic push_item(input spi_op_t op, input logic [LANES-1:0] miso,
                           input logic [31:0] cmd, input logic [2:0] wc,
                           input logic [2:0] rw);
    if (!steady_tx)
      while ($urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_miso_lanes   <= miso;
    in_command_byte <= cmd[31:24];
    in_second_byte  <= cmd[23:16];
    in_third_byte   <= cmd[15:8];
    in_fourth_byte  <= cmd[7:0];
    in_write_count  <= wc;
    in_read_words   <= rw;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // Track idle/busy: a start only takes effect when the engine is idle
    if (op == OP_START) begin
      if (ticks_left == 0) begin
        ticks_left = xfer_ticks(wc, rw);
        xfers_started++;
      end
    end else if (ticks_left > 0) begin
      ticks_left--;
    end
    @(negedge clk);
  endtask

  task automatic push_tick(input miso_mode_t mode);
    push_item(OP_TICK, pick_miso(mode), $urandom(), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)));
  endtask

  // Start a transfer and clock it through. A negative slack cuts it short,
  // a positive one adds idle ticks after CS rises. Optionally fire a second
  // start halfway, which the busy engine must drop.
  task automatic transfer(input logic [31:0] cmd, input logic [2:0] wc,
                          input logic [2:0] rw, input miso_mode_t mode,
                          input int slack, input bit busy_start);
    int n;
    push_item(OP_START, pick_miso(mode), cmd, wc, rw);
    n = xfer_ticks(wc, rw) + slack;
    for (int i = 0; i < n; i++) begin
      if (busy_start && i == n / 2)
        push_item(OP_START, pick_miso(mode), $urandom(), pick_write_count(),
                  pick_read_words());
      push_tick(mode);
    end
  endtask

  // Drop valid and pause until every expected result has been seen
  task automatic wait_results_owed();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  // Finish any open transfer, let results drain, then write the register
  task automatic set_sensor_count(input logic [CNT_W-1:0] count);
    while (ticks_left > 0) push_tick(MISO_RANDOM);
    wait_results_owed();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= count;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    configs_written++;
  endtask

  // Receiver: random stalls, then one long hold-off while the sender keeps
  // offering so the engine backs up into in_stall, a stall-free stretch, then random stalls again.
  initial begin
    int rx_cycle;
    rx_cycle  = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 40 && rx_cycle < 140)
        out_stall <= 1'b1;
      else if (rx_cycle >= 140 && rx_cycle < 340)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  initial begin
    // Drive every input to a known value before reset releases
    rst_n           = 1'b0;
    cfg_write_en    = 1'b0;
    cfg_write_data  = '0;
    in_valid        = 1'b0;
    in_opcode       = OP_TICK;
    in_miso_lanes   = '0;
    in_command_byte = '0;
    in_second_byte  = '0;
    in_third_byte   = '0;
    in_fourth_byte  = '0;
    in_write_count  = '0;
    in_read_words   = '0;
    ticks_left      = 0;
    items_sent      = 0;
    xfers_started   = 0;
    configs_written = 0;
    steady_tx       = 1'b0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ticks while idle must leave the pins parked high
    push_item(OP_TICK, '1, '1, 3'd7, 3'd7);
    push_item(OP_TICK, '0, '0, 3'd0, 3'd0);
    // Write count 0 acts as one byte; a start mid-transfer is dropped;
    // trailing ticks after CS rises are idle ticks again
    transfer(32'hFFFF_FFFF, 3'd0, 3'd0, MISO_HIGH, 2, 1'b1);
    // Lane count above the lane total clamps to all lanes; status byte and
    // one data word, offered back to back
    set_sensor_count(5'd31);
    steady_tx = 1'b1;
    transfer(32'h00FF_A55A, 3'd1, 3'd1, MISO_TOGGLE, 0, 1'b0);
    steady_tx = 1'b0;
    // No lanes enabled: only pin results even at capture ends
    set_sensor_count(5'd0);
    transfer(32'h8001_0180, 3'd1, 3'd0, MISO_RANDOM, 0, 1'b0);

    // Drain, then keep the clock running so any stray result would show
    wait_results_owed();
    repeat (20) @(negedge clk);

    $display("Run covered %0d input transactions, %0d SPI transfers and %0d register writes,",
             items_sent, xfers_started, configs_written);
    $display("with %0d lane captures compared against the predicted waveform.",
             lane_captures);
    if (error_total == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/mlspi_pkg.sv
hdl/mlspi_lane_bank.sv
hdl/multi_lane_spi_command_engine.sv
test/mlspi_result_checker.sv
test/multi_lane_spi_command_engine_tb.sv
